// ===== hw/rtl/nibcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// nibcpu_pkg
// Shared types and constants for the nibble CPU instruction executor.
// ----------------------------------------------------------------------------
package nibcpu_pkg;

   localparam int STACK_DEPTH = 3;
   localparam int CALL_SCALE  = 8;

   localparam int REG_COUNT   = 16;
   localparam int REG_AW      = 4;
   localparam int DATA_W      = 8;
   localparam int PC_W        = 16;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int STACK_IW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int RSP_W       = 40;

   localparam logic [7:0] OP_NOP     = 8'h00;
   localparam logic [7:0] OP_HLT     = 8'hFF;
   localparam logic [7:0] OP_WRR     = 8'hE8;
   localparam logic [3:0] GRP_INC    = 4'h2;
   localparam logic [3:0] GRP_LDM    = 4'hF;
   localparam logic [3:0] GRP_BBL    = 4'hE;
   localparam logic [3:0] GRP_LD     = 4'h9;
   localparam logic [3:0] GRP_CALL   = 4'h4;
   localparam logic [3:0] INC_MASK   = 4'hF;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
   localparam logic [1:0] ERR_BAD_OP    = 2'd3;

   typedef enum logic [3:0] {
      KIND_NOP,
      KIND_HLT,
      KIND_INC,
      KIND_LDM,
      KIND_WRR,
      KIND_BBL,
      KIND_LD,
      KIND_CALL,
      KIND_BAD,
      KIND_IMM
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [3:0]  operand;
   } decode_type;

endpackage

// ===== hw/rtl/nibcpu_ram.sv =====
// ----------------------------------------------------------------------------
// nibcpu_ram
// Generic single-write, single-read RAM with a registered, read-first output.
// ----------------------------------------------------------------------------
module nibcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/nibcpu_decode.sv =====
// ----------------------------------------------------------------------------
// nibcpu_decode
// Instruction decoder: classifies one fetched byte in priority order.
// ----------------------------------------------------------------------------
module nibcpu_decode (
   input  logic [7:0]              instr,
   input  logic                    imm_pending,
   output nibcpu_pkg::decode_type  dec
);
   import nibcpu_pkg::*;

   logic [3:0] hi;

   assign hi = instr[7:4];

   always_comb begin
      dec.operand = instr[3:0];
      if (imm_pending) begin
         dec.kind = KIND_IMM;
      end else if (instr == OP_NOP) begin
         dec.kind = KIND_NOP;
      end else if (instr == OP_HLT) begin
         dec.kind = KIND_HLT;
      end else if (hi == GRP_INC) begin
         dec.kind = KIND_INC;
      end else if (hi == GRP_LDM) begin
         dec.kind = KIND_LDM;
      end else if (instr == OP_WRR) begin
         // WRR shares its group with BBL and must win over it.
         dec.kind = KIND_WRR;
      end else if (hi == GRP_BBL) begin
         dec.kind = KIND_BBL;
      end else if (hi == GRP_LD) begin
         dec.kind = KIND_LD;
      end else if (hi == GRP_CALL) begin
         dec.kind = KIND_CALL;
      end else begin
         dec.kind = KIND_BAD;
      end
   end

endmodule

// ===== hw/rtl/nibble_cpu_instruction_executor_core.sv =====
// ----------------------------------------------------------------------------
// nibble_cpu_instruction_executor_core
// Executes one fetched byte per word of a small 4004-style instruction set.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Ports                          | Contents
//   --------+-----------+--------------------------------+------------------------
//   req     | in        | req_tvalid, req_tready, tdata  | fetched byte
//   rsp     | out       | rsp_tvalid, rsp_tready, tdata  | pc, acc, port, status
//
// One word is accepted per cycle when the result side keeps up. Each word
// passes stage one and then the output register; the register file RAM is
// read in the acceptance cycle and the execute stage uses the read data in
// the next one. The register file write of one word and the read of the
// following word overlap in the same cycle; a one-entry forwarding register
// supplies the fresh value in that case. Reset is synchronous and active high;
// it clears the control state and marks all sixteen registers as zero through
// per-entry written bits, so no clearing pass is needed. A stalled result
// holds the execute stage, which in turn holds the input ready low.
//
module nibble_cpu_instruction_executor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] instr_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] next_pc, [23:16] acc_value, [24] out_strobe, [32:25] out_value,
   // [33] halted, [35:34] error_code, [36] want_immediate, [39:37] zero
   output logic [39:0] rsp_tdata
);
   import nibcpu_pkg::*;

   // Handshake and pipeline control.
   logic accept;
   logic s1_fire;
   logic s1_valid_ff;
   logic [7:0] s1_byte_ff;

   // Register file access and forwarding.
   logic                wr_en;
   logic [REG_AW-1:0]   wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic [DATA_W-1:0]   ram_rdata;
   logic [REG_COUNT-1:0] written_ff;
   logic                rd_written_ff;
   logic                fwd_hit_ff;
   logic [DATA_W-1:0]   fwd_data_ff;
   logic [DATA_W-1:0]   reg_value;

   // Architectural state.
   logic [PC_W-1:0]     pc_ff,       pc_in;
   logic [DATA_W-1:0]   acc_ff,      acc_in;
   logic [PC_W-1:0]     stack_ff [STACK_DEPTH];
   logic [LEVEL_W-1:0]  level_ff,    level_in;
   logic                pend_ff,     pend_in;
   logic [REG_AW-1:0]   pend_idx_ff, pend_idx_in;
   logic                stopped_ff,  stopped_in;
   logic [1:0]          fault_ff,    fault_in;
   logic                push;
   logic                strobe;

   logic [PC_W-1:0]     pc_inc;
   logic [LEVEL_W-1:0]  level_dec;
   logic [PC_W-1:0]     call_target;

   // Output register.
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   decode_type dec;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign accept     = req_tvalid && req_tready;

   nibcpu_decode u_decode (
      .instr       (s1_byte_ff),
      .imm_pending (pend_ff),
      .dec         (dec)
   );

   // The read address is the low nibble of the incoming byte; the execute
   // stage ignores the data when the byte turns out not to need it.
   nibcpu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_COUNT)
   ) u_reg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_tdata[REG_AW-1:0]),
      .rd_data (ram_rdata)
   );

   // A register that was never written reads as zero; a write in the same
   // cycle as the read is forwarded.
   always_comb begin
      if (fwd_hit_ff) begin
         reg_value = fwd_data_ff;
      end else if (rd_written_ff) begin
         reg_value = ram_rdata;
      end else begin
         reg_value = '0;
      end
   end

   assign pc_inc      = pc_ff + PC_W'(1);
   assign level_dec   = level_ff - LEVEL_W'(1);
   assign call_target = PC_W'(32'(dec.operand) * 32'(CALL_SCALE));

   // Execute stage: next state of the machine for the word in stage one.
   always_comb begin
      pc_in       = pc_ff;
      acc_in      = acc_ff;
      level_in    = level_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      stopped_in  = stopped_ff;
      fault_in    = fault_ff;
      push        = 1'b0;
      strobe      = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = dec.operand;
      wr_data     = reg_value;

      if (!stopped_ff) begin
         pc_in = pc_inc;
         case (dec.kind)
            KIND_IMM: begin
               wr_en   = s1_fire;
               wr_addr = pend_idx_ff;
               wr_data = s1_byte_ff;
               pend_in = 1'b0;
            end
            KIND_NOP: begin
            end
            KIND_HLT: begin
               stopped_in = 1'b1;
            end
            KIND_INC: begin
               wr_en   = s1_fire;
               wr_data = {{(DATA_W - 4){1'b0}}, reg_value[3:0] + 4'd1} &
                         {{(DATA_W - 4){1'b0}}, INC_MASK};
            end
            KIND_LDM: begin
               pend_in     = 1'b1;
               pend_idx_in = dec.operand;
            end
            KIND_WRR: begin
               strobe = 1'b1;
            end
            KIND_BBL: begin
               if (level_ff == '0 || level_ff > LEVEL_W'(STACK_DEPTH)) begin
                  stopped_in = 1'b1;
                  fault_in   = ERR_UNDERFLOW;
               end else begin
                  level_in = level_dec;
                  pc_in    = stack_ff[level_dec[STACK_IW-1:0]];
                  acc_in   = {{(DATA_W - 4){1'b0}}, dec.operand};
               end
            end
            KIND_LD: begin
               acc_in = reg_value;
            end
            KIND_CALL: begin
               if (level_ff >= LEVEL_W'(STACK_DEPTH)) begin
                  stopped_in = 1'b1;
                  fault_in   = ERR_OVERFLOW;
               end else begin
                  push     = 1'b1;
                  level_in = level_ff + LEVEL_W'(1);
                  pc_in    = call_target;
               end
            end
            default: begin
               stopped_in = 1'b1;
               fault_in   = ERR_BAD_OP;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in[15:0]    = pc_in;
      rsp_data_in[23:16]   = acc_in;
      rsp_data_in[24]      = strobe;
      rsp_data_in[32:25]   = strobe ? acc_in : '0;
      rsp_data_in[33]      = stopped_in;
      rsp_data_in[35:34]   = fault_in;
      rsp_data_in[36]      = pend_in;
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         written_ff   <= '0;
         pc_ff        <= '0;
         acc_ff       <= '0;
         level_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_idx_ff  <= '0;
         stopped_ff   <= 1'b0;
         fault_ff     <= ERR_NONE;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end

         if (s1_fire) begin
            pc_ff       <= pc_in;
            acc_ff      <= acc_in;
            level_ff    <= level_in;
            pend_ff     <= pend_in;
            pend_idx_ff <= pend_idx_in;
            stopped_ff  <= stopped_in;
            fault_ff    <= fault_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff    <= req_tdata;
         rd_written_ff <= written_ff[req_tdata[REG_AW-1:0]];
         fwd_hit_ff    <= wr_en && (wr_addr == req_tdata[REG_AW-1:0]);
         fwd_data_ff   <= wr_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (s1_fire && push) begin
         stack_ff[level_ff[STACK_IW-1:0]] <= pc_inc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/nibcpu_step_checker.sv =====
// ----------------------------------------------------------------------------
// nibcpu_step_checker
// Watches both streams of the nibble CPU executor, predicts the status word
// for every accepted fetch byte and compares it with the word that comes out.
// ----------------------------------------------------------------------------
module nibcpu_step_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [nibcpu_pkg::RSP_W-1:0] rsp_tdata,
   output int                          mismatch_count,
   output int                          results_outstanding
);
   import nibcpu_pkg::*;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic [DATA_W-1:0] acc_value;
      logic              out_strobe;
      logic [DATA_W-1:0] out_value;
      logic              halted;
      logic [1:0]        error_code;
      logic              want_immediate;
   } step_result_type;

   // Architectural state as the core should hold it.
   logic [PC_W-1:0]   pc_q;
   logic [DATA_W-1:0] acc_q;
   logic [DATA_W-1:0] regs_q [REG_COUNT];
   logic [PC_W-1:0]   ret_stack_q [STACK_DEPTH];
   int                depth_q;
   logic              imm_due_q;
   logic [REG_AW-1:0] imm_reg_q;
   logic              stopped_q;
   logic [1:0]        fault_q;

   step_result_type expected_steps [$];

   // Executes one fetched byte on the predicted state and returns the status word.
   function automatic step_result_type execute_byte(input logic [7:0] fetched);
      step_result_type res;
      logic [3:0]      grp;
      logic [3:0]      arg;
      logic            strobe;
      grp    = fetched[7:4];
      arg    = fetched[3:0];
      strobe = 1'b0;
      if (!stopped_q) begin
         pc_q = pc_q + 1'b1;
         if (imm_due_q) begin
            // The byte is data for the pending LDM and is never decoded.
            regs_q[imm_reg_q] = fetched;
            imm_due_q         = 1'b0;
         end else if (fetched == OP_NOP) begin
         end else if (fetched == OP_HLT) begin
            stopped_q = 1'b1;
         end else if (grp == GRP_INC) begin
            regs_q[arg] = {4'h0, regs_q[arg][3:0] + 4'h1};
         end else if (grp == GRP_LDM) begin
            imm_due_q = 1'b1;
            imm_reg_q = arg;
         end else if (fetched == OP_WRR) begin
            strobe = 1'b1;
         end else if (grp == GRP_BBL) begin
            if (depth_q == 0) begin
               fault_q   = ERR_UNDERFLOW;
               stopped_q = 1'b1;
            end else begin
               depth_q--;
               pc_q  = ret_stack_q[depth_q];
               acc_q = {4'h0, arg};
            end
         end else if (grp == GRP_LD) begin
            acc_q = regs_q[arg];
         end else if (grp == GRP_CALL) begin
            if (depth_q >= STACK_DEPTH) begin
               fault_q   = ERR_OVERFLOW;
               stopped_q = 1'b1;
            end else begin
               ret_stack_q[depth_q] = pc_q;
               depth_q++;
               pc_q = PC_W'(arg * CALL_SCALE);
            end
         end else begin
            fault_q   = ERR_BAD_OP;
            stopped_q = 1'b1;
         end
      end
      res.next_pc        = pc_q;
      res.acc_value      = acc_q;
      res.out_strobe     = strobe;
      res.out_value      = strobe ? acc_q : '0;
      res.halted         = stopped_q;
      res.error_code     = fault_q;
      res.want_immediate = imm_due_q;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      step_result_type want;
      step_result_type got;
      if (reset) begin
         pc_q      = '0;
         acc_q     = '0;
         depth_q   = 0;
         imm_due_q = 1'b0;
         imm_reg_q = '0;
         stopped_q = 1'b0;
         fault_q   = ERR_NONE;
         for (int i = 0; i < REG_COUNT; i++) regs_q[i] = '0;
         for (int i = 0; i < STACK_DEPTH; i++) ret_stack_q[i] = '0;
         expected_steps.delete();
      end else begin
         if (req_tvalid && req_tready) expected_steps.push_back(execute_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.next_pc        = rsp_tdata[15:0];
            got.acc_value      = rsp_tdata[23:16];
            got.out_strobe     = rsp_tdata[24];
            got.out_value      = rsp_tdata[32:25];
            got.halted         = rsp_tdata[33];
            got.error_code     = rsp_tdata[35:34];
            got.want_immediate = rsp_tdata[36];
            if (expected_steps.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected status word %h with no fetch outstanding", rsp_tdata);
            end else begin
               want = expected_steps.pop_front();
               if (got.next_pc != want.next_pc || got.acc_value != want.acc_value ||
                   got.out_strobe != want.out_strobe || got.out_value != want.out_value ||
                   got.halted != want.halted || got.error_code != want.error_code ||
                   got.want_immediate != want.want_immediate || rsp_tdata[39:37] != 3'b000)
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display(
                        "mismatch, expected pc=%h acc=%h stb=%b out=%h hlt=%b err=%0d imm=%b",
                        want.next_pc, want.acc_value, want.out_strobe, want.out_value,
                        want.halted, want.error_code, want.want_immediate);
                     $display(
                        "  got pc=%h acc=%h stb=%b out=%h hlt=%b err=%0d imm=%b pad=%0d",
                        got.next_pc, got.acc_value, got.out_strobe, got.out_value,
                        got.halted, got.error_code, got.want_immediate, rsp_tdata[39:37]);
                  end
               end
            end
         end
      end
      results_outstanding = expected_steps.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the nibble CPU instruction executor: feeds a program
// byte stream with random gaps and back-pressure, and lets the step checker
// judge every status word.
// ----------------------------------------------------------------------------
module tb_top;
   import nibcpu_pkg::*;

   // Roughly the number of random program bytes after the directed part.
   localparam int RANDOM_WORDS = 1900;
   // The limit leaves ample room for about 2000 words with their random gaps,
   // plus the hold-offs and the drains.
   localparam int CYCLE_LIMIT  = 400000;
   // The receiver stops taking words for this long at two points of the run.
   localparam int HOLD_CYCLES  = 150;

   // The run ends on one of these, since any of them stops the core for good.
   typedef enum int {
      END_BY_HLT,
      END_BY_UNDERFLOW,
      END_BY_OVERFLOW,
      END_BY_BAD_OP
   } ending_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;    // [7:0] instr_byte
   logic             rsp_tvalid;
   logic             rsp_tready;
   // [15:0] next_pc, [23:16] acc_value, [24] out_strobe, [32:25] out_value,
   // [33] halted, [35:34] error_code, [36] want_immediate, [39:37] zero
   logic [RSP_W-1:0] rsp_tdata;

   int mismatch_count;
   int results_outstanding;
   int cycle_count;

   // Shadow of the parts of the core state that decide which bytes are legal
   // next: the return stack depth and whether an LDM immediate is due.
   int call_depth;
   bit imm_next;
   // While a side is calm it inserts no random idle cycles; the receiver's two hold-offs still apply.
   bit sender_calm;
   bit receiver_calm;

   always #4 clock = ~clock;

   nibble_cpu_instruction_executor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   nibcpu_step_checker step_check (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   // Offers one fetch byte and returns once the core has taken it. Ready is
   // sampled at the falling edge, where every signal is settled, so the word
   // is known to be accepted at the following rising edge. The idle gap after
   // the word is drawn here, so valid is lowered only when a gap follows and
   // never lowered and raised again at the same edge.
   task automatic offer_byte(input logic [7:0] fetched);
      int gap;
      bit accepted;
      req_tvalid <= 1'b1;
      req_tdata  <= fetched;
      do begin
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end while (!accepted);
      // Keep the shadow in step with what the core has just executed.
      if (imm_next)
         imm_next = 1'b0;
      else if (fetched[7:4] == GRP_LDM && fetched != OP_HLT)
         imm_next = 1'b1;
      else if (fetched[7:4] == GRP_CALL && call_depth < STACK_DEPTH)
         call_depth++;
      else if (fetched[7:4] == GRP_BBL && fetched != OP_WRR && call_depth > 0)
         call_depth--;
      if ($urandom_range(0, 47) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drops valid and waits until every status word owed has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_outstanding != 0);
      @(posedge clock);
   endtask

   // Draws a legal next byte: an immediate of any value when one is due,
   // otherwise a random opcode that keeps the core running. Returns are only
   // drawn with something on the stack and calls only with room on it.
   function automatic logic [7:0] random_program_byte();
      int         pick;
      logic [3:0] arg;
      if (imm_next) begin
         if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         return 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      arg  = 4'($urandom_range(0, 15));
      if (pick >= 85 && call_depth >= STACK_DEPTH) pick = 55;
      if (pick >= 55 && pick < 70 && call_depth == 0) pick = 70;
      if (pick < 10) return OP_NOP;
      if (pick < 25) return {GRP_INC, arg};
      // LDM of R15 would read as HLT, so the target is one of R0 to R14.
      if (pick < 45) return {GRP_LDM, 4'($urandom_range(0, 14))};
      if (pick < 55) return OP_WRR;
      // BBL 8 would read as WRR.
      if (pick < 70) return {GRP_BBL, (arg == OP_WRR[3:0]) ? 4'h0 : arg};
      if (pick < 85) return {GRP_LD, arg};
      return {GRP_CALL, arg};
   endfunction

   // Receiving side: random gaps before each word, calm stretches without any,
   // and two long hold-offs while the sender keeps offering, which fill the
   // two pipeline stages and force ready low on the fetch side.
   initial begin : result_sink
      int gap;
      int taken;
      bit accepted;
      rsp_tready    = 1'b0;
      receiver_calm = 1'b0;
      taken         = 0;
      repeat (6) @(posedge clock);
      forever begin
         if ($urandom_range(0, 47) == 0) receiver_calm = !receiver_calm;
         if (taken == 400 || taken == 1300)
            gap = HOLD_CYCLES;
         else
            gap = receiver_calm ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            accepted = rsp_tvalid;
            @(posedge clock);
         end while (!accepted);
         taken++;
      end
   end

   // Watchdog: a run that has not finished by now is stuck.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      ending_type ending;
      logic [7:0] fetched;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      call_depth  = 0;
      imm_next    = 1'b0;
      sender_calm = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed program: every instruction but HLT, immediates that look like
      // opcodes, nibble wrap of INC, a full-depth call chain and its unwind.
      offer_byte(OP_NOP);
      offer_byte({GRP_LD, 4'd5});         // register never written reads as zero
      offer_byte({GRP_LDM, 4'd0});
      offer_byte(8'hFF);                  // immediate equal to the HLT opcode
      offer_byte({GRP_LD, 4'd0});         // accumulator at its maximum
      offer_byte(OP_WRR);
      offer_byte({GRP_LDM, 4'd14});
      offer_byte(8'h00);                  // immediate equal to the NOP opcode
      offer_byte({GRP_LD, 4'd14});
      offer_byte({GRP_INC, 4'd0});        // low nibble 0xF wraps to zero
      offer_byte({GRP_INC, 4'd15});
      offer_byte({GRP_LD, 4'd15});
      offer_byte({GRP_LDM, 4'd7});
      offer_byte(OP_WRR);                 // taken as the immediate, not decoded
      offer_byte({GRP_CALL, 4'd0});
      offer_byte({GRP_CALL, 4'd15});
      offer_byte({GRP_CALL, 4'd7});       // stack now full
      offer_byte(OP_WRR);
      offer_byte({GRP_BBL, 4'd15});
      offer_byte({GRP_BBL, 4'd0});
      offer_byte({GRP_BBL, 4'd9});        // stack empty again
      offer_byte({GRP_LD, 4'd7});
      offer_byte({GRP_LDM, 4'd1});
      offer_byte(8'h5A);

      // Let the pipeline run dry once before the random program starts.
      wait_for_results();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) wait_for_results();
         offer_byte(random_program_byte());
      end

      // Stop the core by one of its four halting paths, chosen per run, then
      // show that further bytes leave the held state untouched.
      ending = ending_type'($urandom_range(0, 3));
      if (imm_next) offer_byte(8'($urandom_range(0, 255)));
      case (ending)
         END_BY_HLT: begin
            offer_byte(OP_HLT);
         end
         END_BY_UNDERFLOW: begin
            while (call_depth > 0) offer_byte({GRP_BBL, 4'd3});
            offer_byte({GRP_BBL, 4'($urandom_range(0, 7))});
         end
         END_BY_OVERFLOW: begin
            while (call_depth < STACK_DEPTH) offer_byte({GRP_CALL, 4'($urandom_range(0, 15))});
            offer_byte({GRP_CALL, 4'($urandom_range(0, 15))});
         end
         default: begin
            do fetched = 8'($urandom_range(1, 255));
            while (fetched[7:4] == GRP_INC || fetched[7:4] == GRP_LDM ||
                   fetched[7:4] == GRP_BBL || fetched[7:4] == GRP_LD ||
                   fetched[7:4] == GRP_CALL);
            offer_byte(fetched);
         end
      endcase
      repeat (8) offer_byte(8'($urandom_range(0, 255)));

      // Drain, allow a margin, then judge.
      wait_for_results();
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/nibcpu_pkg.sv
hw/rtl/nibcpu_ram.sv
hw/rtl/nibcpu_decode.sv
hw/rtl/nibble_cpu_instruction_executor_core.sv
tb/nibcpu_step_checker.sv
tb/tb_top.sv
